// File: sv/radio_tx_retry_and_link_stats_core_defines.svh
// ------------------------------------------------------------------------
// Assertion macros for the radio transmit retry / link stats core
// Short wrappers for clocked implication checks, disabled during reset.
// ------------------------------------------------------------------------
`ifndef RADIO_TX_RETRY_AND_LINK_STATS_CORE_DEFINES_SVH
`define RADIO_TX_RETRY_AND_LINK_STATS_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds on that edge
`define RTLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtls same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds on the following edge
`define RTLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtls next-cycle check failed");

`endif

// File: sv/rtls_pkg.sv
// ------------------------------------------------------------------------
// rtls_pkg
// Types and constants for the radio transmit retry and link stats core.
// ------------------------------------------------------------------------
package rtls_pkg;

  // Statistics counter width (counters wrap at this width)
  localparam int COUNT_BITS = 16;
  // Width of the statistics fields on the result beat
  localparam int STAT_W     = 16;

  localparam int INTERVAL_W = 16;
  localparam int RETRY_W    = 8;
  localparam int IDLE_W     = 16;
  localparam int PID_W      = 2;
  localparam int MODE_W     = 3;

  // Command codes
  localparam logic CMD_TICK         = 1'b0;
  localparam logic CMD_RESERVE_FAIL = 1'b1;

  // Link mode code for unreliable messages
  localparam logic [MODE_W-1:0] MODE_UNRELIABLE = '0;

  localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RST = 16'd8759;
  localparam logic [RETRY_W-1:0]    RETRY_STEP          = 8'd8;

  // Input beat
  typedef struct packed {
    logic              command;
    logic              head_valid;
    logic [MODE_W-1:0] head_retry_mode;
    logic              head_is_status;
    logic              radio_ack;
    logic              reserve_ok;
  } rtls_in_t;

  // Result beat
  typedef struct packed {
    logic              send_attempt;
    logic              new_setup;
    logic [PID_W-1:0]  packet_id;
    logic              purged;
    logic              lost;
    logic              status_emit;
    logic [STAT_W-1:0] success_count;
    logic [STAT_W-1:0] failure_count;
    logic [STAT_W-1:0] lost_count;
    logic [STAT_W-1:0] overflow_count;
  } rtls_out_t;

endpackage

// File: sv/radio_tx_retry_and_link_stats_core.sv
// Output: registered; the result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while out_ready holds; the result register frees
//   in the same cycle it is taken, so input and output stream back to back.
// Reset: synchronous, active low; clears the held message, retry budget,
//   idle count, packet id, statistics and sets report_interval to 8759.
// ------------------------------------------------------------------------
// radio_tx_retry_and_link_stats_core
// Per-tick transmit controller: retry of a held message, setup of the
// queue head with a rolling packet id, periodic status reports, and
// wrapping link statistics.
// ------------------------------------------------------------------------
`include "radio_tx_retry_and_link_stats_core_defines.svh"

module radio_tx_retry_and_link_stats_core
  import rtls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rtls_in_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output rtls_out_t             out_data,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [INTERVAL_W-1:0] cfg_wr_data
);

  logic [INTERVAL_W-1:0] report_interval_r;
  logic                  holding_r, holding_nxt;
  logic [RETRY_W-1:0]    retry_left_r, retry_left_nxt;
  logic [IDLE_W-1:0]     idle_ticks_r, idle_ticks_nxt;
  logic [PID_W-1:0]      next_pid_r, next_pid_nxt;
  logic [COUNT_BITS-1:0] acks_r, acks_nxt;
  logic [COUNT_BITS-1:0] nacks_r, nacks_nxt;
  logic [COUNT_BITS-1:0] drops_r, drops_nxt;
  logic [COUNT_BITS-1:0] rsv_fails_r, rsv_fails_nxt;

  logic                  out_valid_r;
  rtls_out_t             out_data_r, out_data_nxt;

  logic                  in_fire;
  logic [IDLE_W-1:0]     idle_inc;
  logic [RETRY_W-1:0]    retry_dec;

  // Handshake: take a beat whenever the result register is empty or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idle_inc  = idle_ticks_r + 1'b1;
  assign retry_dec = retry_left_r - RETRY_STEP;

  // Per-beat decision and state update
  always_comb begin
    holding_nxt    = holding_r;
    retry_left_nxt = retry_left_r;
    idle_ticks_nxt = idle_ticks_r;
    next_pid_nxt   = next_pid_r;
    acks_nxt       = acks_r;
    nacks_nxt      = nacks_r;
    drops_nxt      = drops_r;
    rsv_fails_nxt  = rsv_fails_r;

    out_data_nxt              = '0;

    if (in_data.command == CMD_RESERVE_FAIL) begin
      rsv_fails_nxt = rsv_fails_r + 1'b1;
    end else begin
      idle_ticks_nxt = idle_inc;
      if (holding_r) begin
        // retry path; zero budget means resend without decrement
        if (retry_left_r != '0) begin
          retry_left_nxt = retry_dec;
        end
        if (retry_left_r != '0 && retry_dec == '0) begin
          drops_nxt           = drops_r + 1'b1;
          holding_nxt         = 1'b0;
          out_data_nxt.purged = 1'b1;
          out_data_nxt.lost   = 1'b1;
        end else begin
          out_data_nxt.send_attempt = 1'b1;
          if (in_data.radio_ack) begin
            acks_nxt            = acks_r + 1'b1;
            holding_nxt         = 1'b0;
            out_data_nxt.purged = 1'b1;
          end else begin
            nacks_nxt = nacks_r + 1'b1;
          end
        end
      end else if (in_data.head_valid) begin
        // set up and send the queue head
        out_data_nxt.new_setup    = 1'b1;
        out_data_nxt.packet_id    = next_pid_r;
        out_data_nxt.send_attempt = 1'b1;
        next_pid_nxt              = next_pid_r + 1'b1;
        if (in_data.radio_ack) begin
          acks_nxt = acks_r + 1'b1;
        end else begin
          nacks_nxt = nacks_r + 1'b1;
        end
        if (!in_data.radio_ack && in_data.head_retry_mode != MODE_UNRELIABLE) begin
          retry_left_nxt = {in_data.head_retry_mode, {(RETRY_W-MODE_W){1'b0}}};
          holding_nxt    = 1'b1;
        end else begin
          if (in_data.radio_ack && in_data.head_is_status) begin
            idle_ticks_nxt = '0;
            acks_nxt       = '0;
            nacks_nxt      = '0;
            drops_nxt      = '0;
            rsv_fails_nxt  = '0;
          end
          if (!in_data.radio_ack) begin
            drops_nxt         = drops_r + 1'b1;
            out_data_nxt.lost = 1'b1;
          end
          out_data_nxt.purged = 1'b1;
        end
      end else if (idle_inc > report_interval_r) begin
        // periodic status report, if the outbox has room
        if (in_data.reserve_ok) begin
          out_data_nxt.status_emit = 1'b1;
        end else begin
          rsv_fails_nxt = rsv_fails_r + 1'b1;
        end
      end
    end

    out_data_nxt.success_count  = STAT_W'(acks_nxt);
    out_data_nxt.failure_count  = STAT_W'(nacks_nxt);
    out_data_nxt.lost_count     = STAT_W'(drops_nxt);
    out_data_nxt.overflow_count = STAT_W'(rsv_fails_nxt);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_interval_r <= REPORT_INTERVAL_RST;
    end else if (cfg_wr_en) begin
      report_interval_r <= cfg_wr_data;
    end
  end

  // Controller state and statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r    <= 1'b0;
      retry_left_r <= '0;
      idle_ticks_r <= '0;
      next_pid_r   <= '0;
      acks_r       <= '0;
      nacks_r      <= '0;
      drops_r      <= '0;
      rsv_fails_r  <= '0;
    end else if (in_fire) begin
      holding_r    <= holding_nxt;
      retry_left_r <= retry_left_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      next_pid_r   <= next_pid_nxt;
      acks_r       <= acks_nxt;
      nacks_r      <= nacks_nxt;
      drops_r      <= drops_nxt;
      rsv_fails_r  <= rsv_fails_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  // held message always has a nonzero budget on an 8-step grid
  `RTLS_ASSERT_SAME(a_hold_budget, holding_r,
    (retry_left_r != '0) && (retry_left_r[2:0] == 3'b000))
  // reservation failure beat raises no flags
  `RTLS_ASSERT_NEXT(a_rsv_fail_quiet, in_fire && (in_data.command == CMD_RESERVE_FAIL),
    out_valid_r && !out_data_r.send_attempt && !out_data_r.purged &&
    !out_data_r.status_emit && !out_data_r.new_setup && !out_data_r.lost)
  // a setup always sends, never reports
  `RTLS_ASSERT_SAME(a_setup_sends, out_valid_r && out_data_r.new_setup,
    out_data_r.send_attempt && !out_data_r.status_emit)
  // a lost message is always purged
  `RTLS_ASSERT_SAME(a_lost_purged, out_valid_r && out_data_r.lost, out_data_r.purged)

endmodule

// File: tb/tb.sv
// ------------------------------------------------------------------------
// Testbench for radio_tx_retry_and_link_stats_core
// Sends tick and reservation-fail beats through the valid/ready input
// channel, predicts each result beat in a behavioral outbox model and
// compares every field. Random gaps and stalls run on both channels. The
// report interval is set to several values, each written while idle.
// ------------------------------------------------------------------------
module tb;
  import rtls_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int MODE_SHIFT  = RETRY_W - MODE_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rtls_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rtls_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [INTERVAL_W-1:0] cfg_wr_data = '0;

  // Stimulus and expected result stores
  rtls_in_t  tick_beats_q[$];
  rtls_out_t tick_results_q[$];

  // Behavioral outbox state
  logic                  held = 1'b0;
  logic [RETRY_W-1:0]    budget = '0;
  logic [IDLE_W-1:0]     quiet_ticks = '0;
  logic [PID_W-1:0]      pid_next = '0;
  logic [COUNT_BITS-1:0] ack_cnt = '0;
  logic [COUNT_BITS-1:0] nack_cnt = '0;
  logic [COUNT_BITS-1:0] drop_cnt = '0;
  logic [COUNT_BITS-1:0] rsv_fail_cnt = '0;
  logic [INTERVAL_W-1:0] report_gap = REPORT_INTERVAL_RST;

  logic in_taken = 1'b0;
  int   mismatches = 0;
  int   stuck_cycles = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   gap_left = 0;
  int   stall_left = 0;

  radio_tx_retry_and_link_stats_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // One tick of the outbox: returns the result beat, updates the state
  function automatic rtls_out_t predict_tick(input rtls_in_t beat);
    rtls_out_t res;
    logic      expired;
    res = '0;
    expired = 1'b0;
    if (beat.command == CMD_RESERVE_FAIL) begin
      rsv_fail_cnt++;
    end else begin
      quiet_ticks++;
      if (held) begin
        // held message: head fields are ignored, zero budget never expires
        if (budget != '0) begin
          budget = budget - RETRY_STEP;
          expired = (budget == '0);
        end
        if (expired) begin
          drop_cnt++;
          held = 1'b0;
          res.purged = 1'b1;
          res.lost = 1'b1;
        end else begin
          res.send_attempt = 1'b1;
          if (beat.radio_ack) begin
            ack_cnt++;
            held = 1'b0;
            res.purged = 1'b1;
          end else begin
            nack_cnt++;
          end
        end
      end else if (beat.head_valid) begin
        res.new_setup = 1'b1;
        res.packet_id = pid_next;
        pid_next++;
        res.send_attempt = 1'b1;
        if (beat.radio_ack) ack_cnt++;
        else nack_cnt++;
        if (!beat.radio_ack && beat.head_retry_mode != MODE_UNRELIABLE) begin
          budget = RETRY_W'(beat.head_retry_mode) << MODE_SHIFT;
          held = 1'b1;
        end else begin
          // status report acked on first send clears the statistics
          if (beat.radio_ack && beat.head_is_status) begin
            quiet_ticks = '0;
            ack_cnt = '0;
            nack_cnt = '0;
            drop_cnt = '0;
            rsv_fail_cnt = '0;
          end
          if (!beat.radio_ack) begin
            drop_cnt++;
            res.lost = 1'b1;
          end
          res.purged = 1'b1;
        end
      end else if (quiet_ticks > report_gap) begin
        if (beat.reserve_ok) res.status_emit = 1'b1;
        else rsv_fail_cnt++;
      end
    end
    res.success_count  = STAT_W'(ack_cnt);
    res.failure_count  = STAT_W'(nack_cnt);
    res.lost_count     = STAT_W'(drop_cnt);
    res.overflow_count = STAT_W'(rsv_fail_cnt);
    return res;
  endfunction

  function automatic rtls_in_t make_beat(input logic cmd, input logic hv,
                                         input logic [MODE_W-1:0] mode,
                                         input logic st, input logic ack,
                                         input logic room);
    rtls_in_t b;
    b.command = cmd;
    b.head_valid = hv;
    b.head_retry_mode = mode;
    b.head_is_status = st;
    b.radio_ack = ack;
    b.reserve_ok = room;
    return b;
  endfunction

  // Idle length: mostly short, a few long
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [STAT_W-1:0] exp_v,
                             input logic [STAT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Random traffic: retry runs with random content, plus single beats
  task automatic push_random_beats(input int n);
    int                pushed;
    int                run_len;
    logic [MODE_W-1:0] mode;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(99) < 30) begin
        mode = ($urandom_range(3) == 0) ? MODE_W'($urandom_range(1, 7))
                                        : MODE_W'($urandom_range(1, 2));
        tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, mode, 1'($urandom_range(1)),
                                         1'b0, 1'($urandom_range(1))));
        run_len = int'(mode) * 4 + $urandom_range(0, 2);
        for (int i = 0; i < run_len; i++) begin
          tick_beats_q.push_back(make_beat($urandom_range(9) == 0, 1'($urandom_range(1)),
                                           MODE_W'($urandom_range(7)),
                                           1'($urandom_range(1)),
                                           $urandom_range(15) == 0,
                                           1'($urandom_range(1))));
        end
        pushed += run_len + 1;
      end else begin
        tick_beats_q.push_back(make_beat($urandom_range(9) == 0, 1'($urandom_range(1)),
                                         MODE_W'($urandom_range(7)),
                                         $urandom_range(3) == 0,
                                         1'($urandom_range(1)), 1'($urandom_range(1))));
        pushed++;
      end
    end
  endtask

  // Wait until every beat is sent and every result has come back
  task automatic drain();
    while (tick_beats_q.size() != 0 || in_valid || tick_results_q.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_beats_q.size() > 0) begin
        in_data <= tick_beats_q.pop_front();
        in_valid <= 1'b1;
        gap_left = ($urandom_range(99) < gap_pct) ? pick_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(99) < stall_pct) stall_left = pick_len();
    end
  end

  // Monitor: predict on input beats, check result beats
  always @(posedge clk) begin
    rtls_out_t exp_r;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (cfg_wr_en) report_gap = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          $display("%0t: result beat with none expected: actual %h", $time, out_data);
          mismatches++;
        end else begin
          exp_r = tick_results_q.pop_front();
          check_field("send_attempt", STAT_W'(exp_r.send_attempt),
                      STAT_W'(out_data.send_attempt));
          check_field("new_setup", STAT_W'(exp_r.new_setup), STAT_W'(out_data.new_setup));
          check_field("packet_id", STAT_W'(exp_r.packet_id), STAT_W'(out_data.packet_id));
          check_field("purged", STAT_W'(exp_r.purged), STAT_W'(out_data.purged));
          check_field("lost", STAT_W'(exp_r.lost), STAT_W'(out_data.lost));
          check_field("status_emit", STAT_W'(exp_r.status_emit),
                      STAT_W'(out_data.status_emit));
          check_field("success_count", exp_r.success_count, out_data.success_count);
          check_field("failure_count", exp_r.failure_count, out_data.failure_count);
          check_field("lost_count", exp_r.lost_count, out_data.lost_count);
          check_field("overflow_count", exp_r.overflow_count, out_data.overflow_count);
        end
      end
      if (in_valid && in_ready) tick_results_q.push_back(predict_tick(in_data));
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed checks at the reset interval
    gap_pct = 20;
    stall_pct = 20;
    // reservation failure with every other field set
    tick_beats_q.push_back(make_beat(CMD_RESERVE_FAIL, 1'b1, 3'd7, 1'b1, 1'b1, 1'b1));
    // unreliable head: nack drops it, ack purges it
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, MODE_UNRELIABLE, 1'b0, 1'b0, 1'b0));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, MODE_UNRELIABLE, 1'b0, 1'b1, 1'b1));
    // reliable head held; head fields ignored, reservation fail in between
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd7, 1'b0, 1'b0, 1'b0));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd3, 1'b1, 1'b0, 1'b1));
    tick_beats_q.push_back(make_beat(CMD_RESERVE_FAIL, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b0,
                                     1'b0));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b1, 1'b0));
    // smallest budget runs out; the ack on the expiring tick is ignored
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd1, 1'b0, 1'b0, 1'b0));
    repeat (3) tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd5, 1'b1, 1'b0, 1'b0));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd5, 1'b1, 1'b1, 1'b0));
    // status head acked on first send clears the statistics
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd2, 1'b1, 1'b1, 1'b0));
    // status head acked only on retry: no clear
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b1, 3'd2, 1'b1, 1'b0, 1'b0));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b1, 1'b0));
    // idle tick, report not yet due
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b0, 1'b1));

    // report due every idle tick: with room, then outbox full
    write_interval('0);
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b0, 1'b1));
    tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_UNRELIABLE, 1'b0, 1'b0, 1'b0));
    gap_pct = 30;
    stall_pct = 30;
    push_random_beats(140);

    // largest interval, back to back without idling
    write_interval('1);
    gap_pct = 0;
    stall_pct = 0;
    push_random_beats(140);

    write_interval(INTERVAL_W'($urandom_range(1, 40)));
    gap_pct = 50;
    stall_pct = 50;
    push_random_beats(140);

    // idle stretch at a mid-range interval
    write_interval(16'd100);
    gap_pct = 2;
    stall_pct = 2;
    repeat (30)
      tick_beats_q.push_back(make_beat(CMD_TICK, 1'b0, MODE_W'($urandom_range(7)),
                                       1'($urandom_range(1)), 1'($urandom_range(1)),
                                       $urandom_range(3) == 0));

    write_interval('0);
    gap_pct = 15;
    stall_pct = 15;
    push_random_beats(90);

    drain();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/rtls_pkg.sv
sv/radio_tx_retry_and_link_stats_core.sv
tb/tb.sv
